### hw/rtl/transform_matrix_accumulator_defines.svh
// ----------------------------------------------------------------------------
// transform_matrix_accumulator_defines
// assertion macros used by the transform_matrix_accumulator rtl
// ----------------------------------------------------------------------------
`ifndef TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH
`define TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH

// property checked on every rising clk_i edge outside reset
`define TMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define TMA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/tma_pkg.sv
// ----------------------------------------------------------------------------
// tma_pkg
// types, constants and widths shared by the transform matrix accumulator
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int DEPTH     = 16;
  localparam int CNT_W     = 6;
  // magnitude width of the ortho dividends
  localparam int NUM_W     = (2 * FRAC_BITS + 2 > FRAC_BITS + 33) ?
                             2 * FRAC_BITS + 2 : FRAC_BITS + 33;
  localparam int NUM_SW    = NUM_W + 1;
  localparam int DEN_W     = 33;
  localparam int ACC_W     = 2 * DATA_W + 2 - FRAC_BITS;
  localparam int NT        = 6;

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_IDENT = 2'd0,
    CMD_SCALE = 2'd1,
    CMD_ORTHO = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_IDENT,
    S_DIV_START,
    S_DIV_WAIT,
    S_MAC,
    S_MAC_DRAIN,
    S_COPY,
    S_EMIT,
    S_EMIT_LD
  } state_e;

  // one multiply-accumulate step: row, column, inner index
  typedef struct packed {
    logic       valid;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] k;
  } mac_ctl_t;

  // nonconstant entries of the transform: t00 t03 t11 t13 t22 t23
  typedef logic [NT-1:0][DATA_W-1:0] tvec_t;

endpackage

### hw/rtl/transform_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// transform_matrix_accumulator
// 4x4 Q16.16 transform matrix: identity, scale and ortho premultiply
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | command, operand_a..operand_f
// out     | output    | out_valid_o/out_ready_i | element_index, element_value,
//         |           |                       | overflow, last (16 per command)
//
// one command at a time; in_ready_o is high while idle
// identity: identity write pass, then emit; scale: mac pass, drain and
//   copy pass, then emit; ortho adds 6 divisions ahead of the mac pass
// emit reads each entry through the one read port of the matrix ram
// after reset an init pass writes the identity before the first transfer
// a stalled output holds the fsm in emit; the last entry may wait while
//   the next command is accepted
// ----------------------------------------------------------------------------
`include "transform_matrix_accumulator_defines.svh"

module transform_matrix_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic signed [31:0]              operand_a_i,
  input  logic signed [31:0]              operand_b_i,
  input  logic signed [31:0]              operand_c_i,
  input  logic signed [31:0]              operand_d_i,
  input  logic signed [31:0]              operand_e_i,
  input  logic signed [31:0]              operand_f_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      element_index_o,
  output logic signed [31:0]              element_value_o,
  output logic                            overflow_o,
  output logic                            last_o
);

  tma_pkg::state_e                   state_q, state_d;
  logic [tma_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic                              ovf_q, ovf_d;
  logic [tma_pkg::DATA_W-1:0]        opnd_q [tma_pkg::NT];
  tma_pkg::tvec_t                    tvec_q, tvec_d;
  logic                              opnd_load;

  logic                              copy_wr_q, copy_wr_d;
  logic [tma_pkg::IDX_W-1:0]         copy_addr_q;

  logic                              out_valid_q, out_valid_d;
  logic [3:0]                        out_idx_q;
  logic [tma_pkg::DATA_W-1:0]        out_val_q;
  logic                              out_ovf_q, out_last_q;
  logic                              out_load;

  logic                              cur_we, init_we;
  logic [tma_pkg::IDX_W-1:0]         cur_waddr, cur_raddr;
  logic [tma_pkg::DATA_W-1:0]        cur_wdata, cur_rdata;
  logic [tma_pkg::DATA_W-1:0]        prd_rdata;

  tma_pkg::mac_ctl_t                 mac_issue;
  logic                              mac_pwe, mac_sat, mac_busy;
  logic [tma_pkg::IDX_W-1:0]         mac_pwaddr;
  logic [tma_pkg::DATA_W-1:0]        mac_pwdata;

  logic                              div_start, div_done, div_sat;
  logic [tma_pkg::DATA_W-1:0]        div_quot;
  logic signed [tma_pkg::NUM_SW-1:0] div_num;
  logic signed [tma_pkg::DEN_W-1:0]  div_den;
  logic [1:0]                        pair;
  logic signed [tma_pkg::DEN_W-1:0]  op_lo, op_hi;
  logic signed [tma_pkg::DEN_W:0]    op_sum;
  logic signed [tma_pkg::NUM_SW-1:0] sum_ext;
  logic                              zero_range;

  // ortho operand selection: divisions 0..5 give t00 t03 t11 t13 t22 t23
  assign pair    = cnt_q[2:1];
  assign op_lo   = tma_pkg::DEN_W'($signed(opnd_q[{pair, 1'b0}]));
  assign op_hi   = tma_pkg::DEN_W'($signed(opnd_q[{pair, 1'b1}]));
  assign op_sum  = (tma_pkg::DEN_W + 1)'(op_hi) + (tma_pkg::DEN_W + 1)'(op_lo);
  assign sum_ext = tma_pkg::NUM_SW'(op_sum);
  assign div_den = op_hi - op_lo;

  always_comb begin
    if (cnt_q[0]) begin
      div_num = tma_pkg::NUM_SW'(0) - (sum_ext <<< tma_pkg::FRAC_BITS);
    end else if (pair == 2'd2) begin
      div_num = tma_pkg::NUM_SW'(0) - (tma_pkg::NUM_SW'(1) << (2 * tma_pkg::FRAC_BITS + 1));
    end else begin
      div_num = tma_pkg::NUM_SW'(1) << (2 * tma_pkg::FRAC_BITS + 1);
    end
  end

  assign zero_range = (operand_a_i == operand_b_i) || (operand_c_i == operand_d_i) ||
                      (operand_e_i == operand_f_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q | mac_sat;
    tvec_d    = tvec_q;
    opnd_load = 1'b0;
    in_ready_o = 1'b0;
    init_we   = 1'b0;
    cur_raddr = cnt_q[3:0];
    mac_issue = '0;
    div_start = 1'b0;
    copy_wr_d = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      tma_pkg::S_INIT, tma_pkg::S_IDENT: begin
        init_we = 1'b1;
        cnt_d   = cnt_q + tma_pkg::CNT_W'(1);
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d   = '0;
          state_d = (state_q == tma_pkg::S_INIT) ? tma_pkg::S_IDLE : tma_pkg::S_EMIT;
        end
      end
      tma_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          opnd_load = 1'b1;
          ovf_d     = 1'b0;
          cnt_d     = '0;
          case (tma_pkg::cmd_e'(command_i))
            tma_pkg::CMD_IDENT: state_d = tma_pkg::S_IDENT;
            tma_pkg::CMD_SCALE: begin
              tvec_d  = {32'd0, operand_c_i, 32'd0, operand_b_i, 32'd0, operand_a_i};
              state_d = tma_pkg::S_MAC;
            end
            tma_pkg::CMD_ORTHO: begin
              if (zero_range) begin
                ovf_d   = 1'b1;
                state_d = tma_pkg::S_EMIT;
              end else begin
                state_d = tma_pkg::S_DIV_START;
              end
            end
            default: state_d = tma_pkg::S_EMIT;
          endcase
        end
      end
      tma_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_d   = tma_pkg::S_DIV_WAIT;
      end
      tma_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          tvec_d[cnt_q[2:0]] = div_quot;
          ovf_d = ovf_q | div_sat;
          if (cnt_q[2:0] == 3'd5) begin
            cnt_d   = '0;
            state_d = tma_pkg::S_MAC;
          end else begin
            cnt_d   = cnt_q + tma_pkg::CNT_W'(1);
            state_d = tma_pkg::S_DIV_START;
          end
        end
      end
      tma_pkg::S_MAC: begin
        // count is {row, column, inner}; read M[inner][column]
        mac_issue = '{valid: 1'b1, r: cnt_q[5:4], c: cnt_q[3:2], k: cnt_q[1:0]};
        cur_raddr = {cnt_q[1:0], cnt_q[3:2]};
        cnt_d     = cnt_q + tma_pkg::CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = tma_pkg::S_MAC_DRAIN;
        end
      end
      tma_pkg::S_MAC_DRAIN: begin
        if (!mac_busy) begin
          cnt_d   = '0;
          state_d = tma_pkg::S_COPY;
        end
      end
      tma_pkg::S_COPY: begin
        copy_wr_d = 1'b1;
        cnt_d     = cnt_q + tma_pkg::CNT_W'(1);
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d   = '0;
          state_d = tma_pkg::S_EMIT;
        end
      end
      tma_pkg::S_EMIT: begin
        // output register is free at the next edge
        if (!out_valid_q || out_ready_i) begin
          state_d = tma_pkg::S_EMIT_LD;
        end
      end
      tma_pkg::S_EMIT_LD: begin
        out_load = 1'b1;
        cnt_d    = cnt_q + tma_pkg::CNT_W'(1);
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d   = '0;
          state_d = tma_pkg::S_IDLE;
        end else begin
          state_d = tma_pkg::S_EMIT;
        end
      end
      default: state_d = tma_pkg::S_IDLE;
    endcase
  end

  // copy pass writes current from the registered product read
  assign cur_we    = init_we || copy_wr_q;
  assign cur_waddr = copy_wr_q ? copy_addr_q : cnt_q[3:0];
  assign cur_wdata = copy_wr_q ? prd_rdata :
                     ((cnt_q[1:0] == cnt_q[3:2]) ? tma_pkg::ONE_FX : '0);

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tma_pkg::S_INIT;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      copy_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      copy_wr_q   <= copy_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tvec_q      <= tvec_d;
    copy_addr_q <= cnt_q[3:0];
    if (opnd_load) begin
      opnd_q[0] <= operand_a_i;
      opnd_q[1] <= operand_b_i;
      opnd_q[2] <= operand_c_i;
      opnd_q[3] <= operand_d_i;
      opnd_q[4] <= operand_e_i;
      opnd_q[5] <= operand_f_i;
    end
    if (out_load) begin
      out_idx_q  <= cnt_q[3:0];
      out_val_q  <= cur_rdata;
      out_ovf_q  <= ovf_q;
      out_last_q <= (cnt_q[3:0] == 4'd15);
    end
  end

  tma_ram #(
    .WIDTH (tma_pkg::DATA_W),
    .DEPTH (tma_pkg::DEPTH)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  tma_ram #(
    .WIDTH (tma_pkg::DATA_W),
    .DEPTH (tma_pkg::DEPTH)
  ) u_prd_ram (
    .clk_i   (clk_i),
    .we_i    (mac_pwe),
    .waddr_i (mac_pwaddr),
    .wdata_i (mac_pwdata),
    .raddr_i (cnt_q[3:0]),
    .rdata_o (prd_rdata)
  );

  tma_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (mac_issue),
    .rdata_i  (cur_rdata),
    .tvec_i   (tvec_q),
    .pwe_o    (mac_pwe),
    .pwaddr_o (mac_pwaddr),
    .pwdata_o (mac_pwdata),
    .sat_o    (mac_sat),
    .busy_o   (mac_busy)
  );

  tma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .sat_o   (div_sat)
  );

  assign out_valid_o     = out_valid_q;
  assign element_index_o = out_idx_q;
  assign element_value_o = out_val_q;
  assign overflow_o      = out_ovf_q;
  assign last_o          = out_last_q;

  `TMA_ASSERT(a_emit_slot_free, (state_q == tma_pkg::S_EMIT_LD) |-> !out_valid_q, "output register overwritten")
  `TMA_ASSERT_NEVER(a_idle_mac, (state_q == tma_pkg::S_IDLE) && mac_busy, "mac active while idle")
  `TMA_ASSERT(a_div_done_wait, div_done |-> (state_q == tma_pkg::S_DIV_WAIT), "divider result unclaimed")
  `TMA_ASSERT_NEVER(a_write_clash, copy_wr_q && init_we, "two writers on matrix ram")

endmodule

### hw/rtl/tma_ram.sv
// ----------------------------------------------------------------------------
// tma_ram
// generic one-write one-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module tma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tma_div.sv
// ----------------------------------------------------------------------------
// tma_div
// signed restoring divider, one quotient bit per cycle, saturates to 32 bits
// ----------------------------------------------------------------------------
module tma_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tma_pkg::NUM_SW-1:0]     num_i,
  input  logic signed [tma_pkg::DEN_W-1:0]      den_i,
  output logic                                  done_o,
  output logic [tma_pkg::DATA_W-1:0]            quot_o,
  output logic                                  sat_o
);

  localparam int STEP_W = $clog2(tma_pkg::NUM_W + 1);

  logic                         busy_q, busy_d;
  logic                         fin_q, fin_d;
  logic                         neg_q, neg_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [tma_pkg::NUM_W-1:0]    n_q, n_d;
  logic [tma_pkg::DEN_W-1:0]    dv_q, dv_d;
  logic [tma_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic                         done_q, done_d;
  logic [tma_pkg::DATA_W-1:0]   quot_q, quot_d;
  logic                         sat_q, sat_d;
  logic [tma_pkg::DEN_W:0]      trial;
  logic [tma_pkg::DEN_W:0]      diff;
  logic [tma_pkg::NUM_SW-1:0]   num_abs;
  logic [tma_pkg::DEN_W-1:0]    den_abs;

  assign num_abs = num_i[tma_pkg::NUM_SW-1] ? (tma_pkg::NUM_SW'(0) - num_i) : num_i;
  assign den_abs = den_i[tma_pkg::DEN_W-1] ? (tma_pkg::DEN_W'(0) - den_i) : den_i;
  assign trial   = {rem_q, n_q[tma_pkg::NUM_W-1]};
  assign diff    = trial - {1'b0, dv_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    n_d    = n_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    quot_d = quot_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[tma_pkg::NUM_SW-1] ^ den_i[tma_pkg::DEN_W-1];
      n_d    = num_abs[tma_pkg::NUM_W-1:0];
      dv_d   = den_abs;
      rem_d  = '0;
      step_d = STEP_W'(tma_pkg::NUM_W);
    end else if (busy_q) begin
      if (!diff[tma_pkg::DEN_W]) begin
        rem_d = diff[tma_pkg::DEN_W-1:0];
        n_d   = {n_q[tma_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[tma_pkg::DEN_W-1:0];
        n_d   = {n_q[tma_pkg::NUM_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      // sign and clamp the quotient magnitude
      done_d = 1'b1;
      if (neg_q) begin
        if (n_q > {{(tma_pkg::NUM_W-32){1'b0}}, 32'h8000_0000}) begin
          quot_d = 32'h8000_0000;
          sat_d  = 1'b1;
        end else begin
          quot_d = 32'd0 - n_q[31:0];
          sat_d  = 1'b0;
        end
      end else begin
        if (n_q > {{(tma_pkg::NUM_W-32){1'b0}}, 32'h7fff_ffff}) begin
          quot_d = 32'h7fff_ffff;
          sat_d  = 1'b1;
        end else begin
          quot_d = n_q[31:0];
          sat_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    n_q    <= n_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule

### hw/rtl/tma_mac.sv
// ----------------------------------------------------------------------------
// tma_mac
// multiply-accumulate pipeline: T row times M column, writes product ram
// ----------------------------------------------------------------------------
module tma_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tma_pkg::mac_ctl_t             issue_i,
  input  logic [tma_pkg::DATA_W-1:0]    rdata_i,
  input  tma_pkg::tvec_t                tvec_i,
  output logic                          pwe_o,
  output logic [tma_pkg::IDX_W-1:0]     pwaddr_o,
  output logic [tma_pkg::DATA_W-1:0]    pwdata_o,
  output logic                          sat_o,
  output logic                          busy_o
);

  localparam logic signed [tma_pkg::ACC_W-1:0] SAT_MAX =
    tma_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [tma_pkg::ACC_W-1:0] SAT_MIN =
    tma_pkg::ACC_W'(-64'sd2147483648);

  tma_pkg::mac_ctl_t                       s1_q, s2_q;
  logic signed [tma_pkg::DATA_W-1:0]       t_val;
  logic signed [2*tma_pkg::DATA_W-1:0]     prod_q, prod_d;
  logic signed [2*tma_pkg::DATA_W-1:0]     prod_sh;
  logic signed [tma_pkg::ACC_W-1:0]        acc_q, acc_d, acc_base;

  // transform entry at (r, k); row 3 is (0 0 0 1)
  always_comb begin
    t_val = '0;
    if (s1_q.r == 2'd3) begin
      if (s1_q.k == 2'd3) begin
        t_val = tma_pkg::ONE_FX;
      end
    end else if (s1_q.k == s1_q.r) begin
      t_val = tvec_i[{s1_q.r, 1'b0}];
    end else if (s1_q.k == 2'd3) begin
      t_val = tvec_i[{s1_q.r, 1'b1}];
    end
  end

  assign prod_d   = t_val * $signed(rdata_i);
  // arithmetic shift drops the low bits toward minus infinity
  assign prod_sh  = prod_q >>> tma_pkg::FRAC_BITS;
  assign acc_base = (s2_q.k == 2'd0) ? '0 : acc_q;
  assign acc_d    = acc_base + tma_pkg::ACC_W'(prod_sh);

  always_comb begin
    pwe_o    = s2_q.valid && (s2_q.k == 2'd3);
    pwaddr_o = {s2_q.r, s2_q.c};
    sat_o    = 1'b0;
    pwdata_o = acc_d[tma_pkg::DATA_W-1:0];
    if (acc_d > SAT_MAX) begin
      pwdata_o = 32'h7fff_ffff;
      sat_o    = pwe_o;
    end else if (acc_d < SAT_MIN) begin
      pwdata_o = 32'h8000_0000;
      sat_o    = pwe_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= issue_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o = s1_q.valid || s2_q.valid;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives identity, scale, ortho and unused commands into the transform
// matrix accumulator with random gaps and output stalls, predicts the
// sixteen matrix entries of each command and checks them in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = tma_pkg::FRAC_BITS;

  typedef struct {
    tma_pkg::cmd_e      cmd;
    logic signed [31:0] a, b, c, d, e, f;
  } command_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               ovf;
    logic               last;
  } entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i = tma_pkg::CMD_IDENT;
  logic signed [31:0] operand_a_i = '0, operand_b_i = '0, operand_c_i = '0;
  logic signed [31:0] operand_d_i = '0, operand_e_i = '0, operand_f_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         element_index_o;
  logic signed [31:0] element_value_o;
  logic               overflow_o;
  logic               last_o;

  transform_matrix_accumulator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  command_t           pending_cmds[$];
  entry_t             expected_entries[$];
  logic signed [31:0] matrix[16];
  bit                 saturated;
  int                 mismatches = 0;
  int                 entries_checked = 0;
  int                 overflow_entries = 0;
  int                 cmd_count[4] = '{0, 0, 0, 0};
  int                 send_gap = 0;
  int                 stall_left = 0;

  // random idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      saturated = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      saturated = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // floor of the fixed-point product
  function automatic logic signed [63:0] fx_product(input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
    logic signed [63:0] wx, wy;
    wx = x;
    wy = y;
    return (wx * wy) >>> FRAC_BITS;
  endfunction

  task automatic premultiply(input logic signed [31:0] t[16]);
    logic signed [31:0] nxt[16];
    logic signed [63:0] acc;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += fx_product(t[r*4+k], matrix[k*4+c]);
        nxt[r*4+c] = clamp32(acc);
      end
    end
    matrix = nxt;
  endtask

  task automatic load_identity();
    for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? 32'sd1 <<< FRAC_BITS : '0;
  endtask

  task automatic predict_matrix(input command_t it);
    logic signed [31:0] t[16];
    logic signed [63:0] a, b, c, d, e, f, w, h, dp, two2, one;
    entry_t             ex;
    a = it.a; b = it.b; c = it.c; d = it.d; e = it.e; f = it.f;
    one = 64'sd1 <<< FRAC_BITS;
    two2 = 64'sd2 <<< (2 * FRAC_BITS);
    for (int i = 0; i < 16; i++) t[i] = '0;
    saturated = 1'b0;
    cmd_count[it.cmd]++;
    case (it.cmd)
      tma_pkg::CMD_IDENT: load_identity();
      tma_pkg::CMD_SCALE: begin
        t[0] = it.a;
        t[5] = it.b;
        t[10] = it.c;
        t[15] = one[31:0];
        premultiply(t);
      end
      tma_pkg::CMD_ORTHO: begin
        w = b - a;
        h = d - c;
        dp = f - e;
        if (w == 0 || h == 0 || dp == 0) begin
          saturated = 1'b1;
        end else begin
          t[0]  = clamp32(two2 / w);
          t[3]  = clamp32((-(b + a) * one) / w);
          t[5]  = clamp32(two2 / h);
          t[7]  = clamp32((-(d + c) * one) / h);
          t[10] = clamp32(-two2 / dp);
          t[11] = clamp32((-(f + e) * one) / dp);
          t[15] = one[31:0];
          premultiply(t);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) begin
      ex.idx = i;
      ex.val = matrix[i];
      ex.ovf = saturated;
      ex.last = (i == 15);
      expected_entries.push_back(ex);
    end
  endtask

  // input side
  always @(posedge clk_i) begin
    command_t it;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_matrix(pending_cmds.pop_front());
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          // a transfer at this edge has already left the queue
          it = pending_cmds[0];
          command_i   <= it.cmd;
          operand_a_i <= it.a;
          operand_b_i <= it.b;
          operand_c_i <= it.c;
          operand_d_i <= it.d;
          operand_e_i <= it.e;
          operand_f_i <= it.f;
          in_valid_i  <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    entry_t ex;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        entries_checked++;
        if (overflow_o) overflow_entries++;
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: index %0d value %0d", element_index_o,
                     element_value_o);
        end else begin
          ex = expected_entries.pop_front();
          if (element_index_o !== ex.idx || element_value_o !== ex.val ||
              overflow_o !== ex.ovf || last_o !== ex.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp idx %0d val %0d ovf %0b last %0b, ",
                        "got idx %0d val %0d ovf %0b last %0b"},
                       ex.idx, ex.val, ex.ovf, ex.last, element_index_o,
                       element_value_o, overflow_o, last_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] near_value(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic command_t make_cmd(input tma_pkg::cmd_e cmd, input int a,
                                        input int b, input int c, input int d,
                                        input int e, input int f);
    command_t it;
    it.cmd = cmd;
    it.a = a; it.b = b; it.c = c; it.d = d; it.e = e; it.f = f;
    return it;
  endfunction

  function automatic command_t random_cmd();
    command_t it;
    int       r, one;
    one = 1 << FRAC_BITS;
    r = $urandom_range(0, 99);
    it.a = $urandom; it.b = $urandom; it.c = $urandom;
    it.d = $urandom; it.e = $urandom; it.f = $urandom;
    if (r < 10) begin
      it.cmd = tma_pkg::CMD_IDENT;
    end else if (r < 45) begin
      it.cmd = tma_pkg::CMD_SCALE;
      it.a = near_value(3 * one);
      it.b = near_value(3 * one);
      it.c = near_value(3 * one);
    end else if (r < 85) begin
      it.cmd = tma_pkg::CMD_ORTHO;
      it.a = near_value(20 * one);
      it.b = it.a + $urandom_range(1, 40 * one);
      it.c = near_value(20 * one);
      it.d = it.c + near_value(40 * one);
      it.e = near_value(one);
      it.f = it.e + $urandom_range(1, 200 * one);
      if ($urandom_range(0, 19) == 0) it.f = it.e;
    end else if (r < 90) begin
      it.cmd = tma_pkg::CMD_NOP;
    end else begin
      it.cmd = tma_pkg::cmd_e'($urandom_range(0, 3));
    end
    return it;
  endfunction

  initial begin
    int one, tenth;
    one = 1 << FRAC_BITS;
    tenth = one / 10;
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_SCALE, one, one, one, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_SCALE, 2 * one, 3 * one, one / 2,
                                    -1, -1, -1));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_SCALE, -one, -one / 4, 5 * one,
                                    0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_NOP, -1, -1, -1, -1, -1, -1));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_SCALE, 32'h7fffffff, 32'h80000000,
                                    32'h7fffffff, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_IDENT, -1, 0, -1, 0, -1, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, -one, one, -one, one, tenth,
                                    100 * one));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_IDENT, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, 0, 640 * one / 64, 0,
                                    480 * one / 64, -one, one));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, one, one, -one, one, 0, one));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, -one, one, 2 * one, 2 * one,
                                    0, one));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, -one, one, -one, one, 3 * one,
                                    3 * one));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_IDENT, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, 32'h80000000, 32'h7fffffff,
                                    32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                    32'h80000000));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_IDENT, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, 0, 1, 0, -1, 0, 1));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_ORTHO, 32'h7fffffff, 32'h7ffffffe,
                                    32'h80000000, 32'h80000001, 32'h7fffffff,
                                    32'h7ffffffe));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_IDENT, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_SCALE, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(tma_pkg::CMD_NOP, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 190; i++) pending_cmds.push_back(random_cmd());

    load_identity();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_cmds.size() > 0 || in_valid_i || expected_entries.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("commands: %0d identity, %0d scale, %0d ortho, %0d unused", cmd_count[0],
             cmd_count[1], cmd_count[2], cmd_count[3]);
    $display("matrix entries checked: %0d, %0d with overflow flagged, %0d mismatches",
             entries_checked, overflow_entries, mismatches);
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d entries outstanding", expected_entries.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
